// File: rtl/fieldbus_telegram_deframer_top_defines.svh
// Assertion macros for the telegram deframer RTL, used by ftd_parser.
// Expects i_clk and i_rst_n in the scope of the module that uses them.
`ifndef FIELDBUS_TELEGRAM_DEFRAMER_TOP_DEFINES_SVH
`define FIELDBUS_TELEGRAM_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define FTD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, disabled while in reset
`define FTD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

// File: rtl/ftd_pkg.sv
// Package for the fieldbus telegram deframer: result type, codes and constants.
// No dependencies; imported by every deframer module.
`timescale 1ns / 1ps
`default_nettype none

package ftd_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_MASK  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_MATCH = 1'b1;

    // Reset values of the configuration registers
    localparam logic [7:0] CONTROL_MASK_RESET  = 8'hD3;
    localparam logic [7:0] CONTROL_MATCH_RESET = 8'h90;

    // Low info bits give payload length minus one
    localparam logic [7:0] INFO_LEN_MASK = 8'h07;
    // Checksum byte XOR running XOR must give all ones
    localparam logic [7:0] CHECKSUM_GOOD = 8'hFF;

    // Result status codes
    localparam logic [1:0] STATUS_GOOD     = 2'd0;
    localparam logic [1:0] STATUS_BAD      = 2'd1;
    localparam logic [1:0] STATUS_SPURIOUS = 2'd2;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  control_byte;
        logic [15:0] source_address;
        logic [15:0] dest_address;
        logic [7:0]  info_byte;
        logic [63:0] payload;
        logic [3:0]  payload_length;
        logic [7:0]  checksum_byte;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/fieldbus_telegram_deframer_top.sv
// Fieldbus telegram deframer, top level: byte channel in, telegram result channel out.
// Depends on ftd_pkg, ftd_parser and ftd_out_reg.
// Takes one received byte per transfer, one per clock cycle with no gaps as long as the
// result side keeps up. Each byte updates the parser state in the cycle it is accepted;
// a finished telegram (on its checksum byte) or a spurious byte shows up on the result
// channel in the next cycle from a single output register. Input ready drops only while
// that register holds a result the consumer has not taken. Configuration writes take
// effect on the next cycle and should only be made while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module fieldbus_telegram_deframer_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ftd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [7:0]                     i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [7:0]                     i_rx_byte,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [1:0]                          o_status,
    output logic [7:0]                          o_control_byte,
    output logic [15:0]                         o_source_address,
    output logic [15:0]                         o_dest_address,
    output logic [7:0]                          o_info_byte,
    output logic [63:0]                         o_payload,
    output logic [3:0]                          o_payload_length,
    output logic [7:0]                          o_checksum_byte
);
    import ftd_pkg::*;

    logic    accept;
    logic    res_valid;
    logic    free;
    t_result res;
    t_result out_res;

    // Input transfer happens when the result register can take a result
    assign o_in_ready = free;
    assign accept     = i_in_valid && free;

    ftd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ftd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (res_valid),
        .i_res       (res),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_free      (free),
        .o_res       (out_res)
    );

    assign o_status         = out_res.status;
    assign o_control_byte   = out_res.control_byte;
    assign o_source_address = out_res.source_address;
    assign o_dest_address   = out_res.dest_address;
    assign o_info_byte      = out_res.info_byte;
    assign o_payload        = out_res.payload;
    assign o_payload_length = out_res.payload_length;
    assign o_checksum_byte  = out_res.checksum_byte;

endmodule

`default_nettype wire

// File: rtl/ftd_parser.sv
// Telegram parser: frame-start test, field capture, running XOR, result forming.
// Depends on ftd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "fieldbus_telegram_deframer_top_defines.svh"

module ftd_parser (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ftd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [7:0]                     i_cfg_data,
    input  wire logic                           i_accept,
    input  wire logic [7:0]                     i_rx_byte,
    output logic                                o_res_valid,
    output ftd_pkg::t_result                    o_res
);
    import ftd_pkg::*;

    typedef enum logic [2:0] {
        PH_CONTROL = 3'd0,
        PH_SOURCE  = 3'd1,
        PH_DEST    = 3'd2,
        PH_INFO    = 3'd3,
        PH_DATA    = 3'd4,
        PH_CHECK   = 3'd5
    } t_phase;

    logic [7:0]  r_mask, r_match;
    t_phase      r_phase, n_phase;
    logic [3:0]  r_count, n_count;
    logic [3:0]  r_expected, n_expected;
    logic [7:0]  r_control, n_control;
    logic [15:0] r_source, n_source;
    logic [15:0] r_dest, n_dest;
    logic [7:0]  r_info, n_info;
    logic [63:0] r_payload, n_payload;
    logic [7:0]  r_xor, n_xor;
    logic [3:0]  count_inc;
    logic        found;

    assign count_inc = r_count + 4'd1;

    // Per-byte state update and result forming
    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_expected = r_expected;
        n_control  = r_control;
        n_source   = r_source;
        n_dest     = r_dest;
        n_info     = r_info;
        n_payload  = r_payload;
        n_xor      = r_xor;
        found      = 1'b0;
        o_res      = '0;
        case (r_phase)
            PH_SOURCE: begin
                n_source = {r_source[7:0], i_rx_byte};
                n_xor    = r_xor ^ i_rx_byte;
                n_count  = count_inc;
                if (count_inc >= 4'd2) begin
                    n_phase = PH_DEST;
                    n_count = 4'd0;
                    n_dest  = 16'd0;
                end
            end
            PH_DEST: begin
                n_dest  = {r_dest[7:0], i_rx_byte};
                n_xor   = r_xor ^ i_rx_byte;
                n_count = count_inc;
                if (count_inc >= 4'd2) begin
                    n_phase = PH_INFO;
                end
            end
            PH_INFO: begin
                n_info     = i_rx_byte;
                n_xor      = r_xor ^ i_rx_byte;
                n_expected = {1'b0, i_rx_byte[2:0] & INFO_LEN_MASK[2:0]} + 4'd1;
                n_count    = 4'd0;
                n_phase    = PH_DATA;
            end
            PH_DATA: begin
                // write the byte into the lane picked by the count
                for (int k = 0; k < 8; k++) begin
                    if (r_count[2:0] == 3'(k)) begin
                        n_payload[8*k +: 8] = r_payload[8*k +: 8] | i_rx_byte;
                    end
                end
                n_xor   = r_xor ^ i_rx_byte;
                n_count = count_inc;
                if (count_inc >= r_expected) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                found                = 1'b1;
                o_res.status         = ((i_rx_byte ^ r_xor) == CHECKSUM_GOOD) ?
                                       STATUS_GOOD : STATUS_BAD;
                o_res.control_byte   = r_control;
                o_res.source_address = r_source;
                o_res.dest_address   = r_dest;
                o_res.info_byte      = r_info;
                o_res.payload        = r_payload;
                o_res.payload_length = r_expected;
                o_res.checksum_byte  = i_rx_byte;
                n_xor                = r_xor ^ i_rx_byte;
                n_phase              = PH_CONTROL;
            end
            default: begin
                // waiting for a frame start
                if ((i_rx_byte & r_mask) == r_match) begin
                    n_control = i_rx_byte;
                    n_source  = 16'd0;
                    n_dest    = 16'd0;
                    n_payload = 64'd0;
                    n_count   = 4'd0;
                    n_xor     = i_rx_byte;
                    n_phase   = PH_SOURCE;
                end else begin
                    found               = 1'b1;
                    o_res.status        = STATUS_SPURIOUS;
                    o_res.checksum_byte = i_rx_byte;
                end
            end
        endcase
    end

    assign o_res_valid = i_accept && found;

    // Control state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= CONTROL_MASK_RESET;
            r_match <= CONTROL_MATCH_RESET;
            r_phase <= PH_CONTROL;
            r_count <= 4'd0;
            r_xor   <= 8'd0;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_CONTROL_MASK) begin
                r_mask <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == CFG_CONTROL_MATCH) begin
                r_match <= i_cfg_data;
            end
            if (i_accept) begin
                r_phase <= n_phase;
                r_count <= n_count;
                r_xor   <= n_xor;
            end
        end
    end

    // Frame field holding registers; always written before they are read
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_expected <= n_expected;
            r_control  <= n_control;
            r_source   <= n_source;
            r_dest     <= n_dest;
            r_info     <= n_info;
            r_payload  <= n_payload;
        end
    end

    `FTD_ASSERT_NXT(a_check_ends_frame, i_accept && r_phase == PH_CHECK,
        r_phase == PH_CONTROL)
    `FTD_ASSERT_IMP(a_data_count_in_range, r_phase == PH_DATA,
        r_count < r_expected && r_expected >= 4'd1 && r_expected <= 4'd8)
    `FTD_ASSERT_IMP(a_spurious_fields_zero,
        o_res_valid && o_res.status == STATUS_SPURIOUS,
        o_res.payload_length == 4'd0 && o_res.payload == 64'd0)
    `FTD_ASSERT_NXT(a_spurious_keeps_phase,
        o_res_valid && o_res.status == STATUS_SPURIOUS, r_phase == PH_CONTROL)

endmodule

`default_nettype wire

// File: rtl/ftd_out_reg.sv
// Result register between the parser and the output channel.
// Depends on ftd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ftd_out_reg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire ftd_pkg::t_result   i_res,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic                    o_free,
    output ftd_pkg::t_result        o_res
);
    import ftd_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;

    // Free when empty or the held result is transferred this cycle
    assign o_free = !r_valid || i_out_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_out_ready) begin
            n_valid = 1'b0;
        end
        if (i_load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for fieldbus_telegram_deframer_top: it drives received bytes and
// checks each decoded telegram or stray-byte report against an in-bench decoder.
// Depends on ftd_pkg and the deframer RTL only.
`timescale 1ns / 1ps

module testbench;
    import ftd_pkg::*;

    localparam int STALL_LIMIT = 2000;

    // Telegram parse position tracked by the bench decoder
    typedef enum logic [2:0] {
        RX_CONTROL,
        RX_SOURCE,
        RX_DEST,
        RX_INFO,
        RX_PAYLOAD,
        RX_CHECKSUM
    } rx_phase_e;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_CONTROL_MASK;
    logic [7:0] i_cfg_data = 8'h00;
    logic i_in_valid = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    logic [1:0] o_status;
    logic [7:0] o_control_byte;
    logic [15:0] o_source_address;
    logic [15:0] o_dest_address;
    logic [7:0] o_info_byte;
    logic [63:0] o_payload;
    logic [3:0] o_payload_length;
    logic [7:0] o_checksum_byte;

    // Bench copy of the frame filter and the decoder state
    logic [7:0] filt_mask;
    logic [7:0] filt_match;
    rx_phase_e rx_phase;
    logic [3:0] byte_idx;
    logic [3:0] pay_len;
    logic [7:0] ctl_hold;
    logic [15:0] src_hold;
    logic [15:0] dst_hold;
    logic [7:0] info_hold;
    logic [63:0] pay_hold;
    logic [7:0] xor_acc;

    t_result telegram_fifo[$];

    int send_idle_pct = 27;
    int recv_idle_pct = 48;
    int n_bytes = 0;
    int n_good = 0;
    int n_bad = 0;
    int n_stray = 0;
    int n_fail = 0;
    int stall_cycles = 0;

    fieldbus_telegram_deframer_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_control_byte   (o_control_byte),
        .o_source_address (o_source_address),
        .o_dest_address   (o_dest_address),
        .o_info_byte      (o_info_byte),
        .o_payload        (o_payload),
        .o_payload_length (o_payload_length),
        .o_checksum_byte  (o_checksum_byte)
    );

    always #5 i_clk = ~i_clk;

    // Result side backpressure
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Decode one accepted byte; queue the telegram or stray report it produces
    task automatic decode_rx_byte(input logic [7:0] b);
        t_result r;
        r = '0;
        case (rx_phase)
            RX_SOURCE: begin
                src_hold = {src_hold[7:0], b};
                xor_acc ^= b;
                byte_idx++;
                if (byte_idx >= 4'd2) begin
                    rx_phase = RX_DEST;
                    byte_idx = '0;
                    dst_hold = '0;
                end
            end
            RX_DEST: begin
                dst_hold = {dst_hold[7:0], b};
                xor_acc ^= b;
                byte_idx++;
                if (byte_idx >= 4'd2) rx_phase = RX_INFO;
            end
            RX_INFO: begin
                info_hold = b;
                xor_acc ^= b;
                pay_len = 4'((b & INFO_LEN_MASK) + 8'd1);
                byte_idx = '0;
                rx_phase = RX_PAYLOAD;
            end
            RX_PAYLOAD: begin
                pay_hold = pay_hold | (64'(b) << (8 * byte_idx[2:0]));
                xor_acc ^= b;
                byte_idx++;
                if (byte_idx >= pay_len) rx_phase = RX_CHECKSUM;
            end
            RX_CHECKSUM: begin
                r.status = ((b ^ xor_acc) == CHECKSUM_GOOD) ? STATUS_GOOD : STATUS_BAD;
                r.control_byte = ctl_hold;
                r.source_address = src_hold;
                r.dest_address = dst_hold;
                r.info_byte = info_hold;
                r.payload = pay_hold;
                r.payload_length = pay_len;
                r.checksum_byte = b;
                xor_acc ^= b;
                rx_phase = RX_CONTROL;
                if (r.status == STATUS_GOOD) n_good++;
                else n_bad++;
                telegram_fifo.push_back(r);
            end
            default: begin
                if ((b & filt_mask) == filt_match) begin
                    // frame start: clear address and payload holders
                    ctl_hold = b;
                    src_hold = '0;
                    dst_hold = '0;
                    pay_hold = '0;
                    byte_idx = '0;
                    xor_acc = b;
                    rx_phase = RX_SOURCE;
                end else begin
                    r.status = STATUS_SPURIOUS;
                    r.checksum_byte = b;
                    n_stray++;
                    telegram_fifo.push_back(r);
                end
            end
        endcase
    endtask

    // Send one byte; each cycle ahead of it is idle with the sender idle odds.
    // Returns at the transfer edge.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte <= b;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        n_bytes++;
        decode_rx_byte(b);
    endtask

    // Stop sending and let every pending result drain out
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (telegram_fifo.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Write both filter registers on back-to-back edges
    task automatic set_filter(input logic [7:0] mask, input logic [7:0] match);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_CONTROL_MASK;
        i_cfg_data <= mask;
        @(posedge i_clk);
        filt_mask = mask;
        i_cfg_index <= CFG_CONTROL_MATCH;
        i_cfg_data <= match;
        @(posedge i_clk);
        filt_match = match;
        i_cfg_we <= 1'b0;
    endtask

    // Well-formed telegram with random content; optionally bad checksum or cut short
    task automatic send_telegram(input bit corrupt, input int cut_after);
        logic [7:0] frame_bytes[$];
        logic [7:0] acc;
        int n_pay;
        frame_bytes.push_back((filt_match & filt_mask) | (8'($urandom) & ~filt_mask));
        repeat (5) frame_bytes.push_back(8'($urandom));
        n_pay = int'(frame_bytes[5] & INFO_LEN_MASK) + 1;
        repeat (n_pay) frame_bytes.push_back(8'($urandom));
        acc = '0;
        foreach (frame_bytes[i]) acc ^= frame_bytes[i];
        frame_bytes.push_back(corrupt ? (~acc ^ (8'd1 << $urandom_range(0, 7))) : ~acc);
        foreach (frame_bytes[i]) begin
            if (cut_after == 0 || i < cut_after) send_byte(frame_bytes[i]);
        end
    endtask

    // Mix of good telegrams, bad checksums, truncated frames and line noise
    task automatic send_traffic(input int n);
        int start;
        int pick;
        start = n_bytes;
        while (n_bytes - start < n) begin
            pick = $urandom_range(0, 99);
            if ((filt_match & ~filt_mask) != 8'h00 || pick >= 85)
                send_byte(8'($urandom));
            else if (pick < 70)
                send_telegram($urandom_range(0, 4) == 0, 0);
            else
                send_telegram(1'b0, $urandom_range(1, 10));
        end
        // close any open frame so the next filter write lands between telegrams
        while (rx_phase != RX_CONTROL) send_byte(8'($urandom));
    endtask

    // Stray bytes at both extremes, shortest all-zero telegram, longest all-ones one
    task automatic test_directed();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h90);
        repeat (6) send_byte(8'h00);
        send_byte(8'h6F);
        send_byte(8'hBC);
        repeat (13) send_byte(8'hFF);
        send_byte(8'h00);
        wait_idle();
    endtask

    // Filter extremes: exact match, accept-all, reject-all
    task automatic test_filter_extremes();
        logic [7:0] masks[5];
        logic [7:0] match_vals[5];
        masks = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF};
        match_vals = '{8'hA5, 8'h00, 8'hFF, 8'hFF, 8'h00};
        foreach (masks[i]) begin
            set_filter(masks[i], match_vals[i]);
            send_traffic(40);
            wait_idle();
        end
    endtask

    // Long random run with one random filter and the reset filter
    task automatic test_random_traffic(input int snd_pct, input int rcv_pct);
        logic [7:0] mask;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        mask = 8'($urandom);
        set_filter(mask, 8'($urandom) & mask);
        send_traffic(330);
        wait_idle();
        set_filter(CONTROL_MASK_RESET, CONTROL_MATCH_RESET);
        send_traffic(330);
        wait_idle();
    endtask

    // Result checker: compare each result transfer with the oldest queued telegram
    always @(negedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (telegram_fifo.size() == 0) begin
                $error("unexpected result: status %0d checksum_byte %h", o_status,
                       o_checksum_byte);
                n_fail++;
            end else begin
                want = telegram_fifo.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    n_fail++;
                end
                if (o_control_byte !== want.control_byte) begin
                    $error("control_byte: expected %h, got %h", want.control_byte,
                           o_control_byte);
                    n_fail++;
                end
                if (o_source_address !== want.source_address) begin
                    $error("source_address: expected %h, got %h", want.source_address,
                           o_source_address);
                    n_fail++;
                end
                if (o_dest_address !== want.dest_address) begin
                    $error("dest_address: expected %h, got %h", want.dest_address,
                           o_dest_address);
                    n_fail++;
                end
                if (o_info_byte !== want.info_byte) begin
                    $error("info_byte: expected %h, got %h", want.info_byte, o_info_byte);
                    n_fail++;
                end
                if (o_payload !== want.payload) begin
                    $error("payload: expected %h, got %h", want.payload, o_payload);
                    n_fail++;
                end
                if (o_payload_length !== want.payload_length) begin
                    $error("payload_length: expected %0d, got %0d", want.payload_length,
                           o_payload_length);
                    n_fail++;
                end
                if (o_checksum_byte !== want.checksum_byte) begin
                    $error("checksum_byte: expected %h, got %h", want.checksum_byte,
                           o_checksum_byte);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog: too long without any transfer on either channel
    always @(negedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        filt_mask = CONTROL_MASK_RESET;
        filt_match = CONTROL_MATCH_RESET;
        rx_phase = RX_CONTROL;
        byte_idx = '0;
        pay_len = '0;
        ctl_hold = '0;
        src_hold = '0;
        dst_hold = '0;
        info_hold = '0;
        pay_hold = '0;
        xor_acc = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_filter_extremes();
        test_random_traffic(27, 48);
        test_random_traffic(48, 27);
        test_random_traffic(0, 0);

        wait_idle();
        repeat (5) @(posedge i_clk);
        $display("Run covered %0d received bytes under several frame filters and stall mixes.",
                 n_bytes);
        $display("Decoded %0d good and %0d bad-checksum telegrams, %0d stray bytes.",
                 n_good, n_bad, n_stray);
        if (n_fail == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: fieldbus_telegram_deframer_top.f
+incdir+rtl
rtl/ftd_pkg.sv
rtl/ftd_parser.sv
rtl/ftd_out_reg.sv
rtl/fieldbus_telegram_deframer_top.sv
test/testbench.sv
